>>> src/hrit_pkg.sv
package hrit_pkg;

    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 56;
    localparam int unsigned TUSER_OUT_W = 3;

    localparam logic [1:0] SIZE_CODE_4   = 2'd3;
    localparam logic [1:0] TYPE_RESERVED = 2'd3;
    localparam logic [3:0] TAG_LONG      = 4'hf;
    localparam logic [7:0] LEN_FOUR      = 8'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SHORT_DATA,
        PH_LONG_LEN,
        PH_LONG_TAG,
        PH_LONG_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RESERVED = 2'd1,
        ST_TRUNC    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  item_type;
        logic [7:0]  item_tag;
        logic [7:0]  data_length;
        logic [31:0] item_value;
        logic        is_long_item;
        status_t     status;
        logic        end_of_descriptor;
    } result_t;

endpackage

>>> src/hrit_parse.sv
module hrit_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            res_valid,
    output hrit_pkg::result_t res
);
    import hrit_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] value_accum_reg, value_accum_next;
    logic [1:0]  held_type_reg, held_type_next;
    logic [7:0]  held_tag_reg, held_tag_next;
    logic [7:0]  held_length_reg, held_length_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic        error_reg, error_next;

    logic [1:0]  hdr_code;
    logic [1:0]  hdr_type;
    logic [3:0]  hdr_tag;
    logic [7:0]  short_len;
    logic [7:0]  bytes_left_dec;
    logic [31:0] accum_new;

    assign hdr_code       = data_byte[1:0];
    assign hdr_type       = data_byte[3:2];
    assign hdr_tag        = data_byte[7:4];
    assign short_len      = (hdr_code == SIZE_CODE_4) ? LEN_FOUR : {6'd0, hdr_code};
    assign bytes_left_dec = bytes_left_reg - 8'd1;
    assign accum_new      = value_accum_reg
                          | ({24'd0, data_byte} << {byte_position_reg, 3'b000});

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step && !error_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_tag == TAG_LONG)
                        phase_next = PH_LONG_LEN;
                    else if (hdr_type != TYPE_RESERVED && short_len != 8'd0)
                        phase_next = PH_SHORT_DATA;
                end
                PH_SHORT_DATA:
                begin
                    if (bytes_left_dec == 8'd0)
                        phase_next = PH_HEADER;
                end
                PH_LONG_LEN:
                    phase_next = PH_LONG_TAG;
                PH_LONG_TAG:
                begin
                    if (held_length_reg == 8'd0)
                        phase_next = PH_HEADER;
                    else
                        phase_next = PH_LONG_SKIP;
                end
                PH_LONG_SKIP:
                begin
                    if (bytes_left_dec == 8'd0)
                        phase_next = PH_HEADER;
                end
                default:
                    phase_next = PH_HEADER;
            endcase
        end
        if (step && last_byte)
            phase_next = PH_HEADER;
    end

    // results and held fields
    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        value_accum_next   = value_accum_reg;
        held_type_next     = held_type_reg;
        held_tag_next      = held_tag_reg;
        held_length_next   = held_length_reg;
        byte_position_next = byte_position_reg;
        error_next         = error_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.end_of_descriptor = last_byte;
        if (step && !error_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    held_type_next = hdr_type;
                    held_tag_next  = {4'd0, hdr_tag};
                    res.item_type  = hdr_type;
                    res.item_tag   = {4'd0, hdr_tag};
                    if (hdr_tag == TAG_LONG)
                    begin
                        held_length_next = 8'd0;
                        res.is_long_item = 1'b1;
                        res.status       = ST_TRUNC;
                        res_valid        = last_byte;
                    end
                    else
                    begin
                        held_length_next = short_len;
                        res.data_length  = short_len;
                        if (hdr_type == TYPE_RESERVED)
                        begin
                            res.status = ST_RESERVED;
                            res_valid  = 1'b1;
                            error_next = 1'b1;
                        end
                        else if (short_len == 8'd0)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (last_byte)
                        begin
                            res.status = ST_TRUNC;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next    = short_len;
                            value_accum_next   = '0;
                            byte_position_next = 2'd0;
                        end
                    end
                end
                PH_SHORT_DATA:
                begin
                    value_accum_next   = accum_new;
                    byte_position_next = byte_position_reg + 2'd1;
                    bytes_left_next    = bytes_left_dec;
                    res.item_type      = held_type_reg;
                    res.item_tag       = held_tag_reg;
                    res.data_length    = held_length_reg;
                    if (bytes_left_dec == 8'd0)
                    begin
                        res.item_value = accum_new;
                        res_valid      = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        res.status = ST_TRUNC;
                        res_valid  = 1'b1;
                    end
                end
                PH_LONG_LEN:
                begin
                    held_length_next = data_byte;
                    res.item_type    = held_type_reg;
                    res.item_tag     = held_tag_reg;
                    res.data_length  = data_byte;
                    res.is_long_item = 1'b1;
                    res.status       = ST_TRUNC;
                    res_valid        = last_byte;
                end
                PH_LONG_TAG:
                begin
                    held_tag_next    = data_byte;
                    res.item_type    = held_type_reg;
                    res.item_tag     = data_byte;
                    res.data_length  = held_length_reg;
                    res.is_long_item = 1'b1;
                    if (held_length_reg == 8'd0)
                    begin
                        res_valid = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        res.status = ST_TRUNC;
                        res_valid  = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = held_length_reg;
                    end
                end
                PH_LONG_SKIP:
                begin
                    bytes_left_next  = bytes_left_dec;
                    res.item_type    = held_type_reg;
                    res.item_tag     = held_tag_reg;
                    res.data_length  = held_length_reg;
                    res.is_long_item = 1'b1;
                    if (bytes_left_dec == 8'd0)
                    begin
                        res_valid = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        res.status = ST_TRUNC;
                        res_valid  = 1'b1;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
        // last byte always returns the parser to its reset state
        if (step && last_byte)
        begin
            bytes_left_next    = '0;
            value_accum_next   = '0;
            held_type_next     = '0;
            held_tag_next      = '0;
            held_length_next   = '0;
            byte_position_next = '0;
            error_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            bytes_left_reg    <= '0;
            value_accum_reg   <= '0;
            held_type_reg     <= '0;
            held_tag_reg      <= '0;
            held_length_reg   <= '0;
            byte_position_reg <= '0;
            error_reg         <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            value_accum_reg   <= value_accum_next;
            held_type_reg     <= held_type_next;
            held_tag_reg      <= held_tag_next;
            held_length_reg   <= held_length_next;
            byte_position_reg <= byte_position_next;
            error_reg         <= error_next;
        end
    end

endmodule

>>> src/hrit_out_reg.sv
module hrit_out_reg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 load,
    input  hrit_pkg::result_t                    res,
    output logic                                 m_tvalid,
    output logic [hrit_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic [hrit_pkg::TUSER_OUT_W-1:0]     m_tuser,
    output logic                                 m_tlast
);
    import hrit_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.item_value, res_reg.data_length,
                       res_reg.item_tag, res_reg.item_type};
    assign m_tuser  = {res_reg.status, res_reg.is_long_item};
    assign m_tlast  = res_reg.end_of_descriptor;

endmodule

>>> src/hid_report_item_tokenizer_unit.sv
// HID report descriptor item tokenizer.
// Input stream: one descriptor byte per transfer on s_tdata, s_tlast on the
// final byte of a descriptor. Output stream: one transfer per finished item
// (type, tag, length, little-endian value on m_tdata; long flag and status
// on m_tuser; m_tlast set when the item ended on the descriptor's last byte).
// Long items report value 0 and their tag byte; reserved short types report
// status 1 and the parser then drops bytes up to the last one. A descriptor
// that ends inside an item reports status 2.
// A byte is registered on input, parsed combinationally from the input
// register, and its result is registered in the register that drives m_tvalid.
// Throughput: one byte per cycle while m_tready does not stall; the parse
// step is a single combinational state update between the input register and
// the result register. Reset clears the valid flags of both registers and
// puts the parser back to header phase. When the receiver holds m_tready
// low with a result pending, the parse stage stops and s_tready drops once
// the input register is full; no byte or result is lost.
module hid_report_item_tokenizer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hrit_pkg::TDATA_IN_W-1:0]      s_tdata,  // [7:0] data_byte
    input  logic                                 s_tlast,  // last_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] item_type, [9:2] item_tag, [17:10] data_length,
    // [49:18] item_value, [55:50] zero
    output logic [hrit_pkg::TDATA_OUT_W-1:0]     m_tdata,
    // [0] is_long_item, [2:1] status
    output logic [hrit_pkg::TUSER_OUT_W-1:0]     m_tuser,
    output logic                                 m_tlast   // end_of_descriptor
);
    import hrit_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign advance  = !m_tvalid || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hrit_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hrit_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .load     (step && res_valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:1] == ST_TRUNC) |-> m_tlast)
        else $error("truncated item not at end of descriptor");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:1] != ST_OK) |-> (m_tdata[49:18] == 32'd0))
        else $error("error result with nonzero value");

    a_reserved_short: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:1] == ST_RESERVED)
            |-> (!m_tuser[0] && m_tdata[1:0] == TYPE_RESERVED))
        else $error("reserved status on long item or non-reserved type");

    a_long_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[49:18] == 32'd0))
        else $error("long item with nonzero value");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule
